>>> rtl/core/umc_pkg.sv
// ----------------------------------------------------------------------------
// umc_pkg
// Shared types and constants for the motor command decoder: the command
// words, the result status carried between stages, and the duty scaling
// constants.
// ----------------------------------------------------------------------------
`default_nettype none

package umc_pkg;

    localparam int LINE_LIMIT_DEFAULT = 19;

    localparam logic [7:0] BYTE_NEWLINE = 8'd10;
    localparam logic [7:0] BYTE_NUL     = 8'd0;
    localparam logic [7:0] BYTE_ZERO    = 8'd48;
    localparam logic [7:0] BYTE_NINE    = 8'd57;

    localparam logic [6:0] SPEED_MAX   = 7'd99;
    localparam logic [6:0] SPEED_RESET = 7'd50;

    localparam logic [15:0] PERIOD_RESET = 16'd1875;

    // x / 100 == ((x >> 2) * DIV_RECIP) >> DIV_SHIFT for x below 2**23
    localparam int          DIV_SHIFT = 26;
    localparam logic [21:0] DIV_RECIP = 22'd2684355;

    localparam int WORD_COUNT = 3;
    localparam logic [1:0] WORD_ONE  = 2'd0;
    localparam logic [1:0] WORD_TWO  = 2'd1;
    localparam logic [1:0] WORD_STOP = 2'd2;

    localparam logic [127:0] TXT_ONE  = {"motor1", {10{8'h00}}};
    localparam logic [127:0] TXT_TWO  = {"motor2", {10{8'h00}}};
    // stop word, sixteen ASCII bytes, first byte in the top bits
    localparam logic [127:0] TXT_STOP = 128'h4F424A45_544F5F44_45544543_5441444F;

    typedef struct packed {
        logic       run_one;
        logic       run_two;
        logic       pin_one;
        logic       pin_two;
        logic [6:0] speed;
        logic       line_done;
    } motor_stat_t;

    function automatic logic [4:0] word_len(input logic [1:0] k);
        logic [4:0] n;
        begin
            case (k)
                WORD_ONE:  n = 5'd6;
                WORD_TWO:  n = 5'd6;
                WORD_STOP: n = 5'd16;
                default:   n = 5'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [3:0] idx);
        logic [127:0] txt;
        begin
            case (k)
                WORD_ONE:  txt = TXT_ONE;
                WORD_TWO:  txt = TXT_TWO;
                WORD_STOP: txt = TXT_STOP;
                default:   txt = '0;
            endcase
            return txt[8*(4'd15 - idx) +: 8];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/umc_line_parser.sv
// ----------------------------------------------------------------------------
// umc_line_parser
// Collects bytes into lines, matches command words and leading digits,
// updates motor and speed state, and registers one status per item.
// ----------------------------------------------------------------------------
`default_nettype none

module umc_line_parser #(
    parameter int LINE_LIMIT = umc_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rx_valid,
    output logic                     rx_stall,
    input  wire logic [7:0]          rx_byte,
    output logic                     stat_valid,
    input  wire logic                stat_stall,
    output umc_pkg::motor_stat_t     stat
);
    import umc_pkg::*;

    localparam int CW = $clog2(LINE_LIMIT + 1);

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         len_reg, len_next;
    logic                  ended_reg, ended_next;
    logic [WORD_COUNT-1:0] match_reg, match_next;
    logic                  numline_reg, numline_next;
    logic                  open_reg, open_next;
    logic [6:0]            sum_reg, sum_next;
    logic [6:0]            speed_reg, speed_next;
    logic [1:0]            run_reg, run_next;
    logic [1:0]            pin_reg, pin_next;
    logic                  done;
    logic                  digit;
    logic [9:0]            sum_ext;
    logic                  load;
    logic                  valid_reg, valid_next;
    motor_stat_t           stat_reg, stat_next;

    assign rx_stall = valid_reg && stat_stall;
    assign load     = rx_valid && !rx_stall;

    always_comb
    begin
        count_next   = count_reg;
        len_next     = len_reg;
        ended_next   = ended_reg;
        match_next   = match_reg;
        numline_next = numline_reg;
        open_next    = open_reg;
        sum_next     = sum_reg;
        speed_next   = speed_reg;
        run_next     = run_reg;
        sum_ext      = '0;
        digit        = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_NINE);
        done         = (rx_byte == BYTE_NEWLINE) || (count_reg >= CW'(LINE_LIMIT));

        if (!done)
        begin
            count_next = count_reg + 1'b1;
            if (!ended_reg)
            begin
                if (rx_byte == BYTE_NUL)
                begin
                    ended_next = 1'b1;
                    open_next  = 1'b0;
                end
                else
                begin
                    for (int k = 0; k < WORD_COUNT; k++)
                    begin
                        if ((len_reg >= CW'(word_len(2'(k))))
                            || (word_char(2'(k), len_reg[3:0]) != rx_byte))
                            match_next[k] = 1'b0;
                    end
                    if (len_reg == '0)
                    begin
                        numline_next = digit;
                        open_next    = digit;
                    end
                    else if (!digit)
                    begin
                        open_next = 1'b0;
                    end
                    if (open_next)
                    begin
                        sum_ext = {3'b000, sum_reg} * 10'd10 + {6'b000000, rx_byte[3:0]};
                        sum_next = (sum_ext > {3'b000, SPEED_MAX}) ? SPEED_MAX : sum_ext[6:0];
                    end
                    len_next = len_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (match_reg[WORD_ONE] && (len_reg == CW'(word_len(WORD_ONE))))
                run_next = run_reg | 2'b01;
            else if (match_reg[WORD_TWO] && (len_reg == CW'(word_len(WORD_TWO))))
                run_next = run_reg | 2'b10;
            else if (match_reg[WORD_STOP] && (len_reg == CW'(word_len(WORD_STOP))))
                run_next = 2'b00;
            else if (numline_reg)
                speed_next = sum_reg;
            count_next   = '0;
            len_next     = '0;
            ended_next   = 1'b0;
            match_next   = '1;
            numline_next = 1'b0;
            open_next    = 1'b0;
            sum_next     = '0;
        end

        pin_next = pin_reg | run_next;

        stat_next.run_one   = run_next[0];
        stat_next.run_two   = run_next[1];
        stat_next.pin_one   = pin_next[0];
        stat_next.pin_two   = pin_next[1];
        stat_next.speed     = speed_next;
        stat_next.line_done = done;

        valid_next = load ? 1'b1 : (valid_reg && stat_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            len_reg     <= '0;
            ended_reg   <= 1'b0;
            match_reg   <= '1;
            numline_reg <= 1'b0;
            open_reg    <= 1'b0;
            sum_reg     <= '0;
            speed_reg   <= SPEED_RESET;
            run_reg     <= '0;
            pin_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                count_reg   <= count_next;
                len_reg     <= len_next;
                ended_reg   <= ended_next;
                match_reg   <= match_next;
                numline_reg <= numline_next;
                open_reg    <= open_next;
                sum_reg     <= sum_next;
                speed_reg   <= speed_next;
                run_reg     <= run_next;
                pin_reg     <= pin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stat_reg <= stat_next;
    end

    assign stat_valid = valid_reg;
    assign stat       = stat_reg;

endmodule

`default_nettype wire

>>> rtl/core/umc_duty_scaler.sv
// ----------------------------------------------------------------------------
// umc_duty_scaler
// Two-stage duty computation: speed times period, then division by 100
// through a reciprocal multiply. Holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module umc_duty_scaler (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 stat_valid,
    output logic                      stat_stall,
    input  wire umc_pkg::motor_stat_t stat,
    input  wire logic [15:0]          pwm_period,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic                      motor_one_on,
    output logic                      motor_two_on,
    output logic                      dir_one_high,
    output logic                      dir_two_high,
    output logic [6:0]                speed_now,
    output logic [15:0]               duty_one,
    output logic [15:0]               duty_two,
    output logic                      line_done
);
    import umc_pkg::*;

    logic        mid_valid_reg;
    motor_stat_t mid_stat_reg;
    logic [22:0] prod_reg;
    logic        out_valid_reg;
    motor_stat_t out_stat_reg;
    logic [15:0] duty_reg;
    logic        out_ready;
    logic        mid_ready;
    logic        mid_load;
    logic        out_load;
    logic [42:0] recip_prod;

    assign out_ready  = !out_valid_reg || !res_stall;
    assign mid_ready  = !mid_valid_reg || out_ready;
    assign stat_stall = !mid_ready;
    assign mid_load   = stat_valid && mid_ready;
    assign out_load   = mid_valid_reg && out_ready;

    assign recip_prod = {1'b0, prod_reg[22:2]} * {21'd0, DIV_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_ready)
                mid_valid_reg <= stat_valid;
            if (out_ready)
                out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_load)
        begin
            mid_stat_reg <= stat;
            prod_reg     <= {16'd0, stat.speed} * {7'd0, pwm_period};
        end
        if (out_load)
        begin
            out_stat_reg <= mid_stat_reg;
            duty_reg     <= recip_prod[DIV_SHIFT +: 16];
        end
    end

    assign res_valid    = out_valid_reg;
    assign motor_one_on = out_stat_reg.run_one;
    assign motor_two_on = out_stat_reg.run_two;
    assign dir_one_high = out_stat_reg.pin_one;
    assign dir_two_high = out_stat_reg.pin_two;
    assign speed_now    = out_stat_reg.speed;
    assign duty_one     = out_stat_reg.run_one ? duty_reg : 16'd0;
    assign duty_two     = out_stat_reg.run_two ? duty_reg : 16'd0;
    assign line_done    = out_stat_reg.line_done;

endmodule

`default_nettype wire

>>> rtl/core/uart_motor_command_decoder.sv
// Path: a byte accepted at the input passes through the parser, product and
// duty registers, in that order, before its result is on the output.
// Throughput: one byte per cycle; a held result register stalls the input in
// the same cycle once all three stages are full.
// Reset: asynchronous, active low; clears the line, stops both motors,
// clears the direction pins, sets speed to 50 and the period to 1875.
// ----------------------------------------------------------------------------
// uart_motor_command_decoder
// Decodes serial command lines into motor enables, direction pins, speed
// and PWM compare counts.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_motor_command_decoder #(
    parameter int LINE_LIMIT = umc_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             motor_one_on,
    output logic             motor_two_on,
    output logic             dir_one_high,
    output logic             dir_two_high,
    output logic [6:0]       speed_now,
    output logic [15:0]      duty_one,
    output logic [15:0]      duty_two,
    output logic             line_done
);
    import umc_pkg::*;

    logic [15:0] pwm_period_reg;
    logic        stat_valid;
    logic        stat_stall;
    motor_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pwm_period_reg <= PERIOD_RESET;
        else if (cfg_wr_en)
            pwm_period_reg <= cfg_wr_data;
    end

    umc_line_parser #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .stat_valid(stat_valid),
        .stat_stall(stat_stall),
        .stat      (stat)
    );

    umc_duty_scaler u_scaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat_valid  (stat_valid),
        .stat_stall  (stat_stall),
        .stat        (stat),
        .pwm_period  (pwm_period_reg),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .motor_one_on(motor_one_on),
        .motor_two_on(motor_two_on),
        .dir_one_high(dir_one_high),
        .dir_two_high(dir_two_high),
        .speed_now   (speed_now),
        .duty_one    (duty_one),
        .duty_two    (duty_two),
        .line_done   (line_done)
    );

endmodule

`default_nettype wire

>>> rtl/core/umc_checker.sv
// ----------------------------------------------------------------------------
// umc_checker
// Port-level checks on the motor command decoder results, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module umc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        motor_one_on,
    input wire logic        motor_two_on,
    input wire logic        dir_one_high,
    input wire logic [6:0]  speed_now,
    input wire logic [15:0] duty_one,
    input wire logic [15:0] duty_two
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("stalled result dropped");

    a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((motor_one_on || duty_one == 16'd0)
                       && (motor_two_on || duty_two == 16'd0)))
        else $error("nonzero duty on a stopped motor");

    a_dir_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && motor_one_on |-> dir_one_high)
        else $error("motor one runs without direction pin");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> speed_now <= 7'd99)
        else $error("speed above 99");

endmodule

bind uart_motor_command_decoder umc_checker u_umc_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for uart_motor_command_decoder
// Feeds serial command lines (motor words, stop word, speed numbers, zero
// bytes, over-long lines and raw noise) under random source gaps and sink
// stalls. A scoreboard class tracks line state, motor flags and speed,
// predicts each item's status and checks it. The PWM period is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench;

    import umc_pkg::*;

    typedef struct packed {
        logic        run_one;
        logic        run_two;
        logic        pin_one;
        logic        pin_two;
        logic [6:0]  speed;
        logic [15:0] duty_one;
        logic [15:0] duty_two;
        logic        done;
    } motor_result_t;

    class status_board;
        logic [15:0]   period;
        logic [4:0]    stored;
        logic [4:0]    text_len;
        logic          text_cut;
        logic          num_line;
        logic          num_over;
        logic          in_digits;
        logic [2:0]    word_hits;
        logic [6:0]    num_acc;
        logic [6:0]    speed;
        logic [1:0]    running;
        logic [1:0]    pins;
        motor_result_t expected_status[$];
        int            mismatches;
        int            accepted;

        function new();
            period = PERIOD_RESET;
            speed = SPEED_RESET;
            running = 2'b00;
            pins = 2'b00;
            mismatches = 0;
            accepted = 0;
            clear_line();
        endfunction

        function void clear_line();
            stored = '0;
            text_len = '0;
            text_cut = 1'b0;
            num_line = 1'b0;
            num_over = 1'b0;
            in_digits = 1'b0;
            word_hits = 3'b111;
            num_acc = '0;
        endfunction

        function string show(motor_result_t r);
            return $sformatf("on=%0b%0b dir=%0b%0b speed=%0d duty=%0d/%0d done=%0b",
                             r.run_one, r.run_two, r.pin_one, r.pin_two, r.speed,
                             r.duty_one, r.duty_two, r.done);
        endfunction

        function void note_byte(logic [7:0] b);
            motor_result_t r;
            int            hit;
            int            acc;
            int            spd;
            int            duty;
            logic          digit;
            accepted++;
            if (b != BYTE_NEWLINE && stored < LINE_LIMIT_DEFAULT) begin
                stored++;
                if (!text_cut) begin
                    if (b == BYTE_NUL) begin
                        text_cut = 1'b1;
                        in_digits = 1'b0;
                    end
                    else begin
                        for (int k = 0; k < 3; k++) begin
                            if (text_len >= word_len(2'(k))
                                || word_char(2'(k), text_len[3:0]) != b)
                                word_hits[k] = 1'b0;
                        end
                        digit = (b >= BYTE_ZERO && b <= BYTE_NINE);
                        if (text_len == 0) begin
                            num_line = digit;
                            in_digits = digit;
                        end
                        else if (!digit) begin
                            in_digits = 1'b0;
                        end
                        if (in_digits) begin
                            acc = int'(num_acc) * 10 + int'(b - BYTE_ZERO);
                            if (acc > 99) begin
                                acc = 99;
                                num_over = 1'b1;
                            end
                            num_acc = 7'(acc);
                        end
                        text_len++;
                    end
                end
                r.done = 1'b0;
            end
            else begin
                hit = 3;
                for (int k = 2; k >= 0; k--) begin
                    if (word_hits[k] && text_len == word_len(2'(k)))
                        hit = k;
                end
                case (hit)
                    0: running[0] = 1'b1;
                    1: running[1] = 1'b1;
                    2: running = 2'b00;
                    default: if (num_line) speed = num_acc;
                endcase
                clear_line();
                r.done = 1'b1;
            end
            pins = pins | running;
            spd = (speed > SPEED_MAX) ? int'(SPEED_MAX) : int'(speed);
            duty = (spd * int'(period)) / 100;
            r.run_one = running[0];
            r.run_two = running[1];
            r.pin_one = pins[0];
            r.pin_two = pins[1];
            r.speed = 7'(spd);
            r.duty_one = running[0] ? 16'(duty) : 16'd0;
            r.duty_two = running[1] ? 16'(duty) : 16'd0;
            expected_status.push_back(r);
        endfunction

        function void check_result(motor_result_t got);
            motor_result_t want;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status with no byte pending: %s", show(got));
                return;
            end
            want = expected_status.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("status mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_stall;
    logic        motor_one_on;
    logic        motor_two_on;
    logic        dir_one_high;
    logic        dir_two_high;
    logic [6:0]  speed_now;
    logic [15:0] duty_one;
    logic [15:0] duty_two;
    logic        line_done;

    int          tx_max;
    int          rx_max;
    status_board board;

    uart_motor_command_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .motor_one_on (motor_one_on),
        .motor_two_on (motor_two_on),
        .dir_one_high (dir_one_high),
        .dir_two_high (dir_two_high),
        .speed_now    (speed_now),
        .duty_one     (duty_one),
        .duty_two     (duty_two),
        .line_done    (line_done)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_max);
        repeat (gap)
        begin
            @(negedge clk);
            rx_valid <= 1'b0;
        end
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        board.note_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic random_line();
        logic [7:0] q[$];
        int         kw;
        int         wl;
        int         kind;
        int         n;
        logic       term;
        kind = $urandom_range(0, 9);
        term = 1'b1;
        case (kind)
            0, 1, 2:
            begin
                kw = kind;
                wl = int'(word_len(2'(kw)));
                for (int i = 0; i < wl; i++) q.push_back(word_char(2'(kw), 4'(i)));
                if ($urandom_range(0, 3) == 0)
                    q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(32, 126));
                if ($urandom_range(0, 5) == 0)
                    q.push_back(8'($urandom_range(33, 126)));
            end
            3, 4:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) q.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0)
                begin
                    q.push_back(8'($urandom_range(0, 255)));
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++)
                        q.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
                end
            end
            5:
            begin
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(32, 126)));
            end
            6:
            begin
                n = $urandom_range(0, 25);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
            end
            7:
            begin
                n = $urandom_range(17, 24);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(48, 122)));
                term = $urandom_range(0, 1);
            end
            8:
            begin
                kw = $urandom_range(0, 2);
                wl = int'(word_len(2'(kw)));
                for (int i = 0; i < wl; i++) q.push_back(word_char(2'(kw), 4'(i)));
                q.push_back(BYTE_NUL);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(1, 255)));
            end
            default:
            begin
                kw = $urandom_range(0, 2);
                wl = int'(word_len(2'(kw)));
                n = $urandom_range(1, wl - 1);
                for (int i = 0; i < n; i++) q.push_back(word_char(2'(kw), 4'(i)));
            end
        endcase
        if (term) q.push_back(BYTE_NEWLINE);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic drain();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (board.expected_status.size() != 0) @(negedge clk);
    endtask

    initial
    begin : result_sink
        int            hold;
        motor_result_t got;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = $urandom_range(0, rx_max);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            got.run_one = motor_one_on;
            got.run_two = motor_two_on;
            got.pin_one = dir_one_high;
            got.pin_two = dir_two_high;
            got.speed = speed_now;
            got.duty_one = duty_one;
            got.duty_two = duty_two;
            got.done = line_done;
            board.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] periods[6];
        int          start;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rx_valid = 1'b0;
        rx_byte = '0;
        res_stall = 1'b0;
        tx_max = 9;
        rx_max = 9;
        board = new();
        periods[0] = PERIOD_RESET;
        periods[1] = 16'hFFFF;
        periods[2] = 16'd1;
        periods[3] = 16'd0;
        periods[4] = 16'd100;
        periods[5] = 16'($urandom_range(1, 65535));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                drain();
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= periods[p];
                board.period = periods[p];
                @(negedge clk);
                cfg_wr_en <= 1'b0;
            end
            tx_max = (p == 2 || p == 4) ? 0 : 9;
            rx_max = (p == 3 || p == 4) ? 0 : 9;
            if (p == 0)
            begin
                send_text("motor1\n");
                send_text("motor2\n");
                send_text("123\n");
                send_byte(BYTE_NUL);
                send_text("motor1\n");
                send_byte(8'hFF);
                send_byte(8'h80);
                send_byte(BYTE_NEWLINE);
            end
            start = board.accepted;
            while (board.accepted - start < 130) random_line();
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.expected_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/umc_pkg.sv
rtl/core/umc_line_parser.sv
rtl/core/umc_duty_scaler.sv
rtl/core/uart_motor_command_decoder.sv
rtl/core/umc_checker.sv
tb/testbench.sv
